/* sv/ssi_pkg.sv */
// Package for the segment/sphere crossing pipeline: widths, beat structs and a sign-extension helper.
// Depends on nothing; used by ssi_isqrt and segment_sphere_intersect.
`default_nettype none

package ssi_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int TW    = 32;          // fractional bits of t
    localparam int DW    = CW + 1;      // difference width
    localparam int RW    = CW - 1;      // radius width
    localparam int HW    = DW;          // half width of split magnitudes
    localparam int PW    = 2 * DW;      // signed product width
    localparam int MW    = 2 * HW;      // magnitude width of a, |b/2|, |c|
    localparam int SUMW  = PW + 2;
    localparam int BPW   = MW + 1;      // signed b/2
    localparam int CCW   = MW + 1;      // signed c
    localparam int PRW   = 2 * MW;      // wide product width
    localparam int XW    = PRW + 2;     // signed quarter discriminant
    localparam int DISCW = XW + 2;      // discriminant width
    localparam int SQW   = DISCW / 2;   // root width, one stage per bit
    localparam int NUMW  = SQW + 2;     // signed numerator
    localparam int DENW  = MW + 1;      // denominator 2a
    localparam int REMW  = DENW + 1;
    localparam int MPW   = TW + 1 + DW; // t * d

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [RW-1:0] radius;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_out_item;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][DW-1:0] d;
    } t_geom;

    typedef struct packed {
        logic           ok;
        t_geom          geom;
        logic [MW-1:0]  a;
        logic [BPW-1:0] bp;
    } t_mid;

    function automatic logic [DW-1:0] sext(input logic [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

endpackage

`default_nettype wire

/* sv/segment_sphere_intersect.sv */
// Top level: segment against sphere, first crossing, fully pipelined.
// Depends on ssi_pkg and ssi_isqrt.
//
// Use: drive i_item and raise start; a beat is taken at each rising edge where
// start is high and busy is low. busy is high only during reset and for the
// first cycle after it, so once running a beat can enter on every cycle.
// Each beat gives exactly one result: o_valid is high for one cycle with
// o_result holding hit and the crossing point (zero when no hit).
// Throughput: one beat per cycle. Depth is set by the root, one stage per root
// bit (68), and the divider, one stage per bit of t (32), plus ten stages of
// products and sums. The wide products b*b and a*c are split into half-width
// partial products. Reset clears every valid bit; beats in flight are dropped.
// The receiver cannot stall: results are never held back.
`default_nettype none

module segment_sphere_intersect (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire ssi_pkg::t_in_item      i_item,
    output logic                        busy,
    output logic                        o_valid,
    output ssi_pkg::t_out_item          o_result
);

    localparam int CW    = ssi_pkg::CW;
    localparam int DW    = ssi_pkg::DW;
    localparam int RW    = ssi_pkg::RW;
    localparam int HW    = ssi_pkg::HW;
    localparam int PW    = ssi_pkg::PW;
    localparam int MW    = ssi_pkg::MW;
    localparam int SUMW  = ssi_pkg::SUMW;
    localparam int BPW   = ssi_pkg::BPW;
    localparam int CCW   = ssi_pkg::CCW;
    localparam int PRW   = ssi_pkg::PRW;
    localparam int XW    = ssi_pkg::XW;
    localparam int DISCW = ssi_pkg::DISCW;
    localparam int SQW   = ssi_pkg::SQW;
    localparam int NUMW  = ssi_pkg::NUMW;
    localparam int DENW  = ssi_pkg::DENW;
    localparam int REMW  = ssi_pkg::REMW;
    localparam int TW    = ssi_pkg::TW;
    localparam int MPW   = ssi_pkg::MPW;

    logic r_busy;
    logic accept;

    // stage 1: differences
    logic                r1_vld;
    ssi_pkg::t_geom      r1_geom, n1_geom;
    logic [2:0][DW-1:0]  r1_q, n1_q;
    logic [RW-1:0]       r1_r;
    logic [2:0][CW-1:0]  w_st, w_en, w_ce;

    // stage 2: products
    logic                r2_vld;
    ssi_pkg::t_geom      r2_geom;
    logic [2:0][PW-1:0]  r2_dd, r2_dq, r2_qq, n2_dd, n2_dq, n2_qq;
    logic [2*RW-1:0]     r2_rr;

    // stage 3: quadratic coefficients (b held as b/2)
    logic                r3_vld;
    ssi_pkg::t_geom      r3_geom;
    logic [MW-1:0]       r3_a;
    logic [BPW-1:0]      r3_bp;
    logic [CCW-1:0]      r3_c;
    logic [SUMW-1:0]     s3_a, s3_b, s3_c;

    // stage 4: magnitudes
    logic                r4_vld, r4_cneg, r4_az;
    ssi_pkg::t_geom      r4_geom;
    logic [MW-1:0]       r4_a, r4_ab, r4_ac;
    logic [BPW-1:0]      r4_bp, s4_nb;
    logic [CCW-1:0]      s4_nc;

    // stage 5: partial products
    logic                r5_vld, r5_cneg, r5_az;
    ssi_pkg::t_geom      r5_geom;
    logic [MW-1:0]       r5_a;
    logic [BPW-1:0]      r5_bp;
    logic [MW-1:0]       r5_bhh, r5_bhl, r5_bll, r5_ahh, r5_ahl, r5_alh, r5_all;

    // stage 6: b^2/4 and a*|c|
    logic                r6_vld, r6_cneg, r6_az;
    ssi_pkg::t_geom      r6_geom;
    logic [MW-1:0]       r6_a;
    logic [BPW-1:0]      r6_bp;
    logic [PRW-1:0]      r6_bsq, r6_acp;

    // stage 7: discriminant
    logic                r7_vld;
    logic [DISCW-1:0]    r7_disc;
    ssi_pkg::t_mid       r7_side;
    logic [XW-1:0]       s7_x;

    // root
    logic                q_vld;
    logic [SQW-1:0]      q_root;
    ssi_pkg::t_mid       q_side;

    // numerator and bounds
    logic                rn_vld, rn_ok;
    ssi_pkg::t_geom      rn_geom;
    logic [DENW-1:0]     rn_rem, rn_den, sn_den;
    logic [NUMW-1:0]     sn_num;
    logic                sn_ok;

    // divider
    logic [TW-1:0]       r_dv_vld;
    logic [TW-1:0]       r_dv_ok;
    ssi_pkg::t_geom      r_dv_geom [TW];
    logic [DENW-1:0]     r_dv_rem  [TW];
    logic [DENW-1:0]     r_dv_den  [TW];
    logic [TW-1:0]       r_dv_q    [TW];
    logic                w_dv_vld  [TW];
    logic                w_dv_ok   [TW];
    ssi_pkg::t_geom      w_dv_geom [TW];
    logic [DENW-1:0]     w_dv_rem  [TW];
    logic [DENW-1:0]     w_dv_den  [TW];
    logic [TW-1:0]       w_dv_q    [TW];
    logic [REMW-1:0]     n_dv_sh   [TW];
    logic [REMW-1:0]     n_dv_df   [TW];
    logic                n_dv_ge   [TW];
    logic [DENW-1:0]     n_dv_rem  [TW];
    logic [TW-1:0]       n_dv_q    [TW];

    // point products
    logic                rm_vld, rm_ok;
    logic [2:0][CW-1:0]  rm_s;
    logic [2:0][MPW-1:0] rm_prod, nm_prod;
    logic [TW-1:0]       sm_t;

    // output
    logic                r_out_vld;
    ssi_pkg::t_out_item  r_out, n_out;
    logic [2:0][CW-1:0]  nf_pt;

    assign accept = start && !r_busy;

    always_comb begin
        w_st = {i_item.start_z, i_item.start_y, i_item.start_x};
        w_en = {i_item.end_z, i_item.end_y, i_item.end_x};
        w_ce = {i_item.center_z, i_item.center_y, i_item.center_x};
        n1_geom.s = w_st;
        for (int i = 0; i < 3; i++) begin
            n1_geom.d[i] = ssi_pkg::sext(w_en[i]) - ssi_pkg::sext(w_st[i]);
            n1_q[i]      = ssi_pkg::sext(w_st[i]) - ssi_pkg::sext(w_ce[i]);
        end

        for (int i = 0; i < 3; i++) begin
            n2_dd[i] = $signed(r1_geom.d[i]) * $signed(r1_geom.d[i]);
            n2_dq[i] = $signed(r1_geom.d[i]) * $signed(r1_q[i]);
            n2_qq[i] = $signed(r1_q[i]) * $signed(r1_q[i]);
        end

        s3_a = SUMW'($signed(r2_dd[0])) + SUMW'($signed(r2_dd[1]))
             + SUMW'($signed(r2_dd[2]));
        s3_b = SUMW'($signed(r2_dq[0])) + SUMW'($signed(r2_dq[1]))
             + SUMW'($signed(r2_dq[2]));
        s3_c = SUMW'($signed(r2_qq[0])) + SUMW'($signed(r2_qq[1]))
             + SUMW'($signed(r2_qq[2])) - SUMW'(r2_rr);

        s4_nb = -r3_bp;
        s4_nc = -r3_c;

        s7_x = r6_cneg ? (XW'(r6_bsq) + XW'(r6_acp)) : (XW'(r6_bsq) - XW'(r6_acp));

        sn_num = -({{(NUMW-BPW){q_side.bp[BPW-1]}}, q_side.bp} << 1)
               - NUMW'(q_root);
        sn_den = {q_side.a, 1'b0};
        sn_ok  = q_side.ok && !sn_num[NUMW-1] && (sn_num != '0)
              && (sn_num < NUMW'(sn_den));

        w_dv_vld[0]  = rn_vld;
        w_dv_ok[0]   = rn_ok;
        w_dv_geom[0] = rn_geom;
        w_dv_rem[0]  = rn_rem;
        w_dv_den[0]  = rn_den;
        w_dv_q[0]    = '0;
        for (int k = 1; k < TW; k++) begin
            w_dv_vld[k]  = r_dv_vld[k-1];
            w_dv_ok[k]   = r_dv_ok[k-1];
            w_dv_geom[k] = r_dv_geom[k-1];
            w_dv_rem[k]  = r_dv_rem[k-1];
            w_dv_den[k]  = r_dv_den[k-1];
            w_dv_q[k]    = r_dv_q[k-1];
        end
        for (int k = 0; k < TW; k++) begin
            n_dv_sh[k]  = {w_dv_rem[k], 1'b0};
            n_dv_df[k]  = n_dv_sh[k] - REMW'(w_dv_den[k]);
            n_dv_ge[k]  = n_dv_sh[k] >= REMW'(w_dv_den[k]);
            n_dv_rem[k] = n_dv_ge[k] ? n_dv_df[k][DENW-1:0] : n_dv_sh[k][DENW-1:0];
            n_dv_q[k]   = {w_dv_q[k][TW-2:0], n_dv_ge[k]};
        end

        sm_t = r_dv_q[TW-1];
        for (int i = 0; i < 3; i++) begin
            nm_prod[i] = $signed({1'b0, sm_t}) * $signed(r_dv_geom[TW-1].d[i]);
        end

        for (int i = 0; i < 3; i++) begin
            nf_pt[i] = rm_s[i] + rm_prod[i][TW+CW-1:TW];
        end
        n_out.hit     = rm_ok;
        n_out.point_x = rm_ok ? nf_pt[0] : '0;
        n_out.point_y = rm_ok ? nf_pt[1] : '0;
        n_out.point_z = rm_ok ? nf_pt[2] : '0;
    end

    ssi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_disc  (r7_disc),
        .i_side  (r7_side),
        .o_valid (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            rn_vld    <= 1'b0;
            r_dv_vld  <= '0;
            rm_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r1_vld    <= accept;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            rn_vld    <= q_vld;
            for (int k = 0; k < TW; k++) begin
                r_dv_vld[k] <= w_dv_vld[k];
            end
            rm_vld    <= r_dv_vld[TW-1];
            r_out_vld <= rm_vld;
        end

        r1_geom <= n1_geom;
        r1_q    <= n1_q;
        r1_r    <= i_item.radius;

        r2_geom <= r1_geom;
        r2_dd   <= n2_dd;
        r2_dq   <= n2_dq;
        r2_qq   <= n2_qq;
        r2_rr   <= r1_r * r1_r;

        r3_geom <= r2_geom;
        r3_a    <= s3_a[MW-1:0];
        r3_bp   <= s3_b[BPW-1:0];
        r3_c    <= s3_c[CCW-1:0];

        r4_geom <= r3_geom;
        r4_a    <= r3_a;
        r4_bp   <= r3_bp;
        r4_ab   <= r3_bp[BPW-1] ? s4_nb[MW-1:0] : r3_bp[MW-1:0];
        r4_ac   <= r3_c[CCW-1] ? s4_nc[MW-1:0] : r3_c[MW-1:0];
        r4_cneg <= r3_c[CCW-1];
        r4_az   <= (r3_a == '0);

        r5_geom <= r4_geom;
        r5_a    <= r4_a;
        r5_bp   <= r4_bp;
        r5_cneg <= r4_cneg;
        r5_az   <= r4_az;
        r5_bhh  <= r4_ab[MW-1:HW] * r4_ab[MW-1:HW];
        r5_bhl  <= r4_ab[MW-1:HW] * r4_ab[HW-1:0];
        r5_bll  <= r4_ab[HW-1:0] * r4_ab[HW-1:0];
        r5_ahh  <= r4_a[MW-1:HW] * r4_ac[MW-1:HW];
        r5_ahl  <= r4_a[MW-1:HW] * r4_ac[HW-1:0];
        r5_alh  <= r4_a[HW-1:0] * r4_ac[MW-1:HW];
        r5_all  <= r4_a[HW-1:0] * r4_ac[HW-1:0];

        r6_geom <= r5_geom;
        r6_a    <= r5_a;
        r6_bp   <= r5_bp;
        r6_cneg <= r5_cneg;
        r6_az   <= r5_az;
        r6_bsq  <= (PRW'(r5_bhh) << (2 * HW)) + (PRW'(r5_bhl) << (HW + 1))
                 + PRW'(r5_bll);
        r6_acp  <= (PRW'(r5_ahh) << (2 * HW)) + (PRW'(r5_ahl) << HW)
                 + (PRW'(r5_alh) << HW) + PRW'(r5_all);

        r7_disc         <= s7_x[XW-1] ? '0 : {s7_x, 2'b00};
        r7_side.ok      <= !r6_az && !s7_x[XW-1];
        r7_side.geom    <= r6_geom;
        r7_side.a       <= r6_a;
        r7_side.bp      <= r6_bp;

        rn_ok   <= sn_ok;
        rn_geom <= q_side.geom;
        rn_rem  <= sn_ok ? sn_num[DENW-1:0] : '0;
        rn_den  <= sn_den;

        for (int k = 0; k < TW; k++) begin
            r_dv_ok[k]   <= w_dv_ok[k];
            r_dv_geom[k] <= w_dv_geom[k];
            r_dv_rem[k]  <= n_dv_rem[k];
            r_dv_den[k]  <= w_dv_den[k];
            r_dv_q[k]    <= n_dv_q[k];
        end

        rm_ok   <= r_dv_ok[TW-1] && (sm_t != '0);
        rm_s    <= r_dv_geom[TW-1].s;
        rm_prod <= nm_prod;

        r_out   <= n_out;
    end

    assign busy     = r_busy;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* sv/ssi_isqrt.sv */
// Pipelined floor square root of the discriminant, one result bit per stage.
// Depends on ssi_pkg; carries the beat's side data alongside.
`default_nettype none

module ssi_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [ssi_pkg::DISCW-1:0]   i_disc,
    input  wire ssi_pkg::t_mid               i_side,
    output logic                             o_valid,
    output logic [ssi_pkg::SQW-1:0]          o_root,
    output ssi_pkg::t_mid                    o_side
);

    localparam int N = ssi_pkg::SQW;
    localparam int W = ssi_pkg::DISCW;

    logic [N-1:0]  r_vld;
    logic [W-1:0]  r_rem  [N];
    logic [W-1:0]  r_res  [N];
    ssi_pkg::t_mid r_side [N];

    logic          w_vld  [N];
    logic [W-1:0]  w_rem  [N];
    logic [W-1:0]  w_res  [N];
    ssi_pkg::t_mid w_side [N];

    logic [W-1:0]  n_rem  [N];
    logic [W-1:0]  n_res  [N];
    logic [W-1:0]  n_tmp  [N];
    logic [W-1:0]  n_bit  [N];

    always_comb begin
        w_vld[0]  = i_valid;
        w_rem[0]  = i_disc;
        w_res[0]  = '0;
        w_side[0] = i_side;
        for (int k = 1; k < N; k++) begin
            w_vld[k]  = r_vld[k-1];
            w_rem[k]  = r_rem[k-1];
            w_res[k]  = r_res[k-1];
            w_side[k] = r_side[k-1];
        end
        for (int k = 0; k < N; k++) begin
            n_bit[k] = W'(1) << (W - 2 - 2 * k);
            n_tmp[k] = w_res[k] + n_bit[k];
            if (w_rem[k] >= n_tmp[k]) begin
                n_rem[k] = w_rem[k] - n_tmp[k];
                n_res[k] = (w_res[k] >> 1) + n_bit[k];
            end else begin
                n_rem[k] = w_rem[k];
                n_res[k] = w_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                r_vld[k] <= w_vld[k];
            end
        end
        for (int k = 0; k < N; k++) begin
            r_rem[k]  <= n_rem[k];
            r_res[k]  <= n_res[k];
            r_side[k] <= w_side[k];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_res[N-1][N-1:0];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

/* tb/segment_sphere_intersect_test.sv */
// Self-checking bench for segment_sphere_intersect: directed and random segment/sphere beats,
// predicted with exact wide integer arithmetic and compared field by field with each result.
// Depends on ssi_pkg and the segment_sphere_intersect RTL.
`default_nettype none

module segment_sphere_intersect_test;
    import ssi_pkg::*;

    localparam int PIPE_DEPTH = 110;
    localparam int HOLD_AT    = 600;

    typedef logic signed [255:0] t_big;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_in_item   i_item = '0;
    logic       busy;
    logic       o_valid;
    t_out_item  o_result;

    t_in_item   pending_beats[$];
    t_out_item  expected_hits[$];
    int         beats_sent = 0;
    int         results_seen = 0;
    int         hits_seen = 0;
    int         mismatches = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    bit         drained_once = 1'b0;

    segment_sphere_intersect u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_big floor_root(input t_big v);
        t_big rem, res, bit_w, trial;
        rem = v;
        res = '0;
        bit_w = t_big'(1) << 254;
        for (int k = 0; k < 128; k++) begin
            trial = res + bit_w;
            if ($unsigned(rem) >= $unsigned(trial)) begin
                rem = rem - trial;
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic t_out_item first_crossing(input t_in_item it);
        t_big s[3], e[3], ctr[3], d[3], q[3];
        t_big qa, qb, qc, rad, disc, num, den, t, pt;
        t_out_item res;
        res = '0;
        s[0] = it.start_x;  s[1] = it.start_y;  s[2] = it.start_z;
        e[0] = it.end_x;    e[1] = it.end_y;    e[2] = it.end_z;
        ctr[0] = it.center_x; ctr[1] = it.center_y; ctr[2] = it.center_z;
        qa = '0; qb = '0; qc = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = e[i] - s[i];
            q[i] = s[i] - ctr[i];
            qa = qa + d[i] * d[i];
            qb = qb + d[i] * q[i];
            qc = qc + q[i] * q[i];
        end
        qb = qb * 2;
        rad = t_big'({1'b0, it.radius});
        qc = qc - rad * rad;
        if (qa == 0) return res;
        disc = qb * qb - 4 * qa * qc;
        if (disc < 0) return res;
        num = -qb - floor_root(disc);
        if (num <= 0) return res;
        den = 2 * qa;
        if (num >= den) return res;
        t = (num <<< TW) / den;
        if (t == 0) return res;
        res.hit = 1'b1;
        pt = s[0] + ((t * d[0]) >>> TW); res.point_x = pt[CW-1:0];
        pt = s[1] + ((t * d[1]) >>> TW); res.point_y = pt[CW-1:0];
        pt = s[2] + ((t * d[2]) >>> TW); res.point_z = pt[CW-1:0];
        return res;
    endfunction

    function automatic t_in_item make_beat(input int sx, sy, sz, ex, ey, ez,
                                           input int cx, cy, cz, input int unsigned r);
        t_in_item it;
        it.start_x = sx;  it.start_y = sy;  it.start_z = sz;
        it.end_x = ex;    it.end_y = ey;    it.end_z = ez;
        it.center_x = cx; it.center_y = cy; it.center_z = cz;
        it.radius = r[RW-1:0];
        return it;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Segment through a sphere, mostly crossing, with random scale and jitter.
    function automatic t_in_item crossing_beat();
        int cx, cy, cz, ox, oy, oz, span;
        int unsigned r;
        span = 1 << $urandom_range(8, 28);
        cx = spread(1 << 29); cy = spread(1 << 29); cz = spread(1 << 29);
        r  = $urandom_range(0, span);
        ox = spread(span); oy = spread(span); oz = spread(span);
        return make_beat(cx + ox + spread(span / 4), cy + oy, cz + oz,
                         cx - ox, cy - oy + spread(span / 4), cz - oz,
                         cx, cy, cz, r);
    endfunction

    // Driver: bursts with random gaps, one hold until the pipeline drains.
    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_hits.push_back(first_crossing(i_item));
            beats_sent <= beats_sent + 1;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!drained_once && beats_sent >= HOLD_AT && !(start && !busy)) begin
            start <= 1'b0;
            if (expected_hits.size() == 0) drained_once <= 1'b1;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            i_item <= pending_beats.pop_front();
            start <= 1'b1;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else if (beats_sent > 200 && beats_sent < 400) begin
                burst_left <= 50;
            end else begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                        : $urandom_range(0, 4);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: one result per cycle at most, compared in order.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (expected_hits.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat %p", o_result);
            end else begin
                want = expected_hits.pop_front();
                if (want.hit) hits_seen <= hits_seen + 1;
                if (o_result.hit !== want.hit || o_result.point_x !== want.point_x
                        || o_result.point_y !== want.point_y
                        || o_result.point_z !== want.point_z) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result %0d: expected %p, got %p",
                                 results_seen, want, o_result);
                end
            end
        end
    end

    initial begin
        int sel;
        int unsigned m;
        m = 32'h7fff_ffff;
        // directed: extremes, tangent, inside, behind, far side, zero length
        pending_beats.push_back(make_beat(-5 << 16, 0, 0, 5 << 16, 0, 0, 0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(-5 << 16, 1 << 16, 0, 5 << 16, 1 << 16, 0,
                                          0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(0, 0, 0, 5 << 16, 0, 0, 0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(5 << 16, 0, 0, 9 << 16, 0, 0, 0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(-9 << 16, 0, 0, -5 << 16, 0, 0, 0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(-1 << 16, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 1 << 16));
        pending_beats.push_back(make_beat(3, 3, 3, 3, 3, 3, 0, 0, 0, 1));
        pending_beats.push_back(make_beat(-5 << 16, 0, 0, 5 << 16, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(-5 << 16, 0, 0, 5 << 16, 0, 0, 0, 0, 0, 1));
        pending_beats.push_back(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          m, m, m, 0, 0, 0, m));
        pending_beats.push_back(make_beat(m, m, m, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 0, 0, 0, 1 << 20));
        pending_beats.push_back(make_beat(32'h8000_0000, 0, m, m, 0, 32'h8000_0000,
                                          m, 32'h8000_0000, 0, m));
        pending_beats.push_back(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          m, m, m, m, m, m, m));
        pending_beats.push_back(make_beat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, m));
        pending_beats.push_back(make_beat(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(0, -2, 0, 1 << 16, -2, 0, 1 << 15, 0, 0, 2));
        pending_beats.push_back(make_beat(-(1 << 30), 7, -9, 1 << 30, -3, 11,
                                          5, 1, 1, 1 << 28));
        for (int n = 0; n < 1200; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                pending_beats.push_back(crossing_beat());
            else if (sel < 85)
                pending_beats.push_back(make_beat($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
            else if (sel < 92) begin
                pending_beats.push_back(crossing_beat());
                pending_beats[$].end_x = pending_beats[$].start_x;
                pending_beats[$].end_y = pending_beats[$].start_y;
                pending_beats[$].end_z = pending_beats[$].start_z;
            end else
                pending_beats.push_back(make_beat(spread(64), spread(64), spread(64),
                    spread(64), spread(64), spread(64), spread(8), spread(8), spread(8),
                    $urandom_range(0, 40)));
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_beats.size() > 0 || start) @(posedge i_clk);
        while (expected_hits.size() > 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("%0d beats sent, %0d results checked, %0d of them crossings;",
                 beats_sent, results_seen, hits_seen);
        $display("one full drain mid-run, random bursts and gaps, %0d errors", mismatches);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("segment_sphere_intersect: match");
        else
            $display("segment_sphere_intersect: mismatch");
        $finish;
    end

    initial begin
        #(8 * 200000);
        $display("segment_sphere_intersect: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/ssi_pkg.sv
sv/ssi_isqrt.sv
sv/segment_sphere_intersect.sv
tb/segment_sphere_intersect_test.sv
